FILE: sv/imn_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the image max normalizer.
// No dependencies; every other file refers to it by scoped names.

package imn_pkg;

  // Fixed field widths of the channels
  localparam int unsigned PIX_FIELD_W = 16;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned QUO_W       = 16;

  // Reset value of the target intensity register
  localparam logic [CFG_W-1:0] CFG_RESET = 16'd255;

  // Pass codes carried in cmd
  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_SCALE   = 1'b1;

  // Top level sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } imn_state_e;

  // Divider control from the sequencer
  typedef struct packed {
    logic load;   // take a new product
    logic step;   // one quotient bit
    logic first;  // first step: judge overflow
  } imn_div_ctrl_t;

endpackage

FILE: sv/imn_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: pixel input, normalized output, config write.
// Depends on imn_pkg for field widths.

interface imn_in_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic [imn_pkg::PIX_FIELD_W-1:0]    pixel;
  logic                               last;

  modport source (output valid, output cmd, output pixel, output last, input ready);
  modport sink   (input valid, input cmd, input pixel, input last, output ready);
endinterface

interface imn_out_if;
  logic                               valid;
  logic                               ready;
  logic [imn_pkg::QUO_W-1:0]          out_pixel;
  logic                               out_last;
  logic                               zero_max;

  modport source (output valid, output out_pixel, output out_last, output zero_max,
                  input ready);
  modport sink   (input valid, input out_pixel, input out_last, input zero_max,
                  output ready);
endinterface

interface imn_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [imn_pkg::CFG_W-1:0]          target_max;

  modport source (output valid, output target_max, input ready);
  modport sink   (input valid, input target_max, output ready);
endinterface

FILE: sv/imn_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider: one quotient bit per step, dividend shifted MSB first.
// Depends on imn_pkg for the quotient width and the control struct.

module imn_div #(
  parameter int unsigned PIX_W = 16
) (
  input  logic                                 clk_i,
  input  imn_pkg::imn_div_ctrl_t               ctrl_i,
  input  logic [PIX_W+imn_pkg::QUO_W-1:0]      prod_i,
  input  logic [PIX_W-1:0]                     dvs_i,
  output logic [imn_pkg::QUO_W-1:0]            quo_o,
  output logic                                 sat_o
);

  localparam int unsigned QW = imn_pkg::QUO_W;

  logic [PIX_W-1:0] rem_q;
  logic [QW-1:0]    dvd_q;
  logic [QW-1:0]    quo_q;
  logic             sat_q;

  logic [PIX_W:0]   trial;
  logic [PIX_W:0]   diff;
  logic             ge;

  // Trial subtract of the partial remainder with the next dividend bit
  assign trial = {rem_q, dvd_q[QW-1]};
  assign diff  = trial - {1'b0, dvs_i};
  assign ge    = (trial >= {1'b0, dvs_i});

  // Shift registers; quotient bits enter at the LSB
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rem_q <= prod_i[PIX_W+QW-1:QW];
      dvd_q <= prod_i[QW-1:0];
    end else if (ctrl_i.step) begin
      rem_q <= ge ? diff[PIX_W-1:0] : trial[PIX_W-1:0];
      dvd_q <= {dvd_q[QW-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], ge};
      // upper product half at or above the divisor: quotient exceeds QW bits
      if (ctrl_i.first) begin
        sat_q <= (rem_q >= dvs_i);
      end
    end
  end

  assign quo_o = quo_q;
  assign sat_o = sat_q;

endmodule

FILE: sv/image_max_normalizer_unit.sv
`timescale 1ns / 1ps
// Top level of the image max normalizer: peak tracking, multiplier, sequencer.
// Depends on imn_pkg, the channel interfaces in imn_if and the divider imn_div.
//
// Usage: the image is streamed twice on in_i. Items with cmd = 0 (measure pass)
// update the running peak in the cycle of transfer and give no result; they
// can be transferred back to back. Items with cmd = 1 (scale pass) each give
// one result on out_o: target_max * pixel / peak, truncated, saturated to
// all ones, or 0 with zero_max set when the peak is zero. The scale item with
// last set clears the peak for the next image. From transfer to result, a
// scale item passes ST_MUL (the product is loaded into the divider), ST_DIV
// (the bit-serial divider, one quotient bit per step) and ST_OUT (the output
// register is loaded); in_i.ready is low until ST_OUT is left, so no new item
// is taken meanwhile. The output register lets the next item start while a
// result waits; if the receiver stalls, the next result holds in the divider
// until the output register frees. cfg_i is always ready; the user is to
// write it only while the block is idle; the block does not enforce it. Reset
// sets target_max to 255, clears the peak and empties the output register.

module image_max_normalizer_unit #(
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  imn_cfg_if.sink       cfg_i,
  imn_in_if.sink        in_i,
  imn_out_if.source     out_o
);

  localparam int unsigned PixW  = (PIXEL_BITS < imn_pkg::PIX_FIELD_W) ?
                                  PIXEL_BITS : imn_pkg::PIX_FIELD_W;
  localparam int unsigned QW    = imn_pkg::QUO_W;
  localparam int unsigned ProdW = imn_pkg::CFG_W + PixW;
  localparam int unsigned CntW  = $clog2(QW);

  imn_pkg::imn_state_e      state_q, state_d;
  imn_pkg::imn_div_ctrl_t   div_ctrl;

  logic [imn_pkg::CFG_W-1:0] target_q;
  logic [PixW-1:0]           peak_q, peak_d;
  logic [PixW-1:0]           pix_q;
  logic [PixW-1:0]           dvs_q;
  logic                      last_q;
  logic                      zero_q;
  logic [CntW-1:0]           cnt_q, cnt_d;

  logic                      out_valid_q, out_valid_d;
  logic [QW-1:0]             out_pixel_q;
  logic                      out_last_q;
  logic                      out_zero_q;
  logic                      out_load;

  logic                      in_xfer;
  logic                      scale_xfer;
  logic [PixW-1:0]           pix_in;
  logic [ProdW-1:0]          prod;
  logic [QW-1:0]             quo;
  logic                      sat;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == imn_pkg::ST_IDLE);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign scale_xfer  = in_xfer && (in_i.cmd == imn_pkg::CMD_SCALE);
  assign pix_in      = in_i.pixel[PixW-1:0];

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= imn_pkg::CFG_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      target_q <= cfg_i.target_max;
    end
  end

  // Running peak: raised on measure items, cleared by the last scale item
  always_comb begin
    peak_d = peak_q;
    if (in_xfer) begin
      if (in_i.cmd == imn_pkg::CMD_MEASURE) begin
        if (pix_in > peak_q) begin
          peak_d = pix_in;
        end
      end else if (in_i.last) begin
        peak_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
    end else begin
      peak_q <= peak_d;
    end
  end

  // Operands of a scale item, peak captured before it is cleared
  always_ff @(posedge clk_i) begin
    if (scale_xfer) begin
      pix_q  <= pix_in;
      dvs_q  <= peak_q;
      last_q <= in_i.last;
      zero_q <= (peak_q == '0);
    end
  end

  // Product goes straight into the divider registers
  assign prod = ProdW'(target_q) * ProdW'(pix_q);

  imn_div #(
    .PIX_W (PixW)
  ) u_div (
    .clk_i  (clk_i),
    .ctrl_i (div_ctrl),
    .prod_i (prod),
    .dvs_i  (dvs_q),
    .quo_o  (quo),
    .sat_o  (sat)
  );

  // Sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    div_ctrl = '0;
    out_load = 1'b0;
    unique case (state_q)
      imn_pkg::ST_IDLE: begin
        if (scale_xfer) begin
          state_d = imn_pkg::ST_MUL;
        end
      end
      imn_pkg::ST_MUL: begin
        div_ctrl.load = 1'b1;
        cnt_d         = '0;
        state_d       = imn_pkg::ST_DIV;
      end
      imn_pkg::ST_DIV: begin
        div_ctrl.step  = 1'b1;
        div_ctrl.first = (cnt_q == '0);
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(QW - 1)) begin
          state_d = imn_pkg::ST_OUT;
        end
      end
      imn_pkg::ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = imn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = imn_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= imn_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pixel_q <= zero_q ? '0 : (sat ? '1 : quo);
      out_last_q  <= last_q;
      out_zero_q  <= zero_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_pixel = out_pixel_q;
  assign out_o.out_last  = out_last_q;
  assign out_o.zero_max  = out_zero_q;

endmodule

FILE: sv/imn_checker.sv
`timescale 1ns / 1ps
// Port-level checks of image_max_normalizer_unit and the bind that attaches them.
// Depends on imn_pkg for widths and pass codes.

module imn_port_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_cmd,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [imn_pkg::QUO_W-1:0]     out_pixel,
  input logic                          zero_max
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel))
    else $error("result dropped or changed under stall");

  // A zero peak always gives a zero pixel
  a_zero_pix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && zero_max |-> out_pixel == '0)
    else $error("zero_max with nonzero pixel");

  // A measure transfer never produces a result
  a_measure_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_cmd == imn_pkg::CMD_MEASURE && !out_valid |=> !out_valid)
    else $error("result after measure transfer");

  // A scale transfer occupies the block
  a_scale_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_cmd == imn_pkg::CMD_SCALE |=> !in_ready)
    else $error("input ready right after scale transfer");

endmodule

bind image_max_normalizer_unit imn_port_checker u_imn_port_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_cmd    (in_i.cmd),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_pixel (out_o.out_pixel),
  .zero_max  (out_o.zero_max)
);

FILE: test/imn_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the image max normalizer: watches the config, pixel and result channels,
// predicts each normalized pixel and compares it with what the block returns.
// Depends on imn_pkg and the channel interfaces in imn_if.

module imn_checker #(
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  imn_cfg_if   cfg_i,
  imn_in_if    in_i,
  imn_out_if   out_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int unsigned PixFieldW = imn_pkg::PIX_FIELD_W;

  typedef struct packed {
    logic [imn_pkg::QUO_W-1:0] pixel;
    logic                      last;
    logic                      zero_max;
  } norm_result_t;

  // Shadow state of the block
  logic [PixFieldW-1:0]      peak_seen;
  logic [imn_pkg::CFG_W-1:0] target_reg;
  norm_result_t              norm_expect_q[$];

  // One mismatch line, counted
  task automatic report_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  // target * pixel / peak, truncated and saturated; zero peak flagged
  function automatic norm_result_t normalize_pixel(input logic [PixFieldW-1:0] pix,
                                                   input logic last);
    norm_result_t res;
    logic [31:0]  prod;
    logic [31:0]  quo;
    res.pixel    = '0;
    res.last     = last;
    res.zero_max = 1'b0;
    if (peak_seen == '0) begin
      res.zero_max = 1'b1;
    end else begin
      prod = 32'(target_reg) * 32'(pix);
      quo  = prod / 32'(peak_seen);
      res.pixel = (quo > 32'hFFFF) ? 16'hFFFF : quo[imn_pkg::QUO_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    norm_result_t         want;
    logic [PixFieldW-1:0] pix;
    if (!rst_ni) begin
      peak_seen    = '0;
      target_reg   = imn_pkg::CFG_RESET;
      norm_expect_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      // Result transfer: compare with the oldest prediction
      if (out_i.valid && out_i.ready) begin
        if (norm_expect_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with no scale pixel pending", out_i.out_pixel));
        end else begin
          want = norm_expect_q.pop_front();
          if (out_i.out_pixel !== want.pixel)
            report_mismatch($sformatf("out_pixel got %0d, expected %0d",
                                      out_i.out_pixel, want.pixel));
          if (out_i.out_last !== want.last)
            report_mismatch($sformatf("out_last got %b, expected %b",
                                      out_i.out_last, want.last));
          if (out_i.zero_max !== want.zero_max)
            report_mismatch($sformatf("zero_max got %b, expected %b",
                                      out_i.zero_max, want.zero_max));
        end
      end

      // Register write
      if (cfg_i.valid && cfg_i.ready)
        target_reg = cfg_i.target_max;

      // Pixel transfer: measure updates the peak, scale queues a prediction
      if (in_i.valid && in_i.ready) begin
        pix = in_i.pixel;
        if (PIXEL_BITS < PixFieldW)
          pix = pix & PixFieldW'((32'd1 << PIXEL_BITS) - 1);
        if (in_i.cmd == imn_pkg::CMD_MEASURE) begin
          if (pix > peak_seen) peak_seen = pix;
        end else begin
          norm_expect_q.push_back(normalize_pixel(pix, in_i.last));
          if (in_i.last) peak_seen = '0;
        end
      end
      pending_o = norm_expect_q.size();
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Top of the image max normalizer test: clock, reset, pixel and config stimulus,
// receiver back-pressure, watchdog and verdict. Depends on imn_pkg, imn_if,
// image_max_normalizer_unit and imn_checker.

module testbench;

  localparam int unsigned PIX_BITS          = 16;
  localparam int unsigned NO_XFER_LIMIT     = 4000;
  localparam int unsigned DRAIN_CYCLES      = 24;
  localparam int unsigned HOLD_CYCLES       = 200;
  localparam int unsigned ITEMS_PER_SETTING = 125;

  logic clk;
  logic rst_n;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   hold_pending  = 1'b0;
  int   quiet_cycles  = 0;
  int   items_sent    = 0;
  int   fail_count;
  int   pending;

  imn_in_if  in_if();
  imn_out_if out_if();
  imn_cfg_if cfg_if();

  image_max_normalizer_unit #(
    .PIXEL_BITS(PIX_BITS)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  imn_checker #(
    .PIXEL_BITS(PIX_BITS)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_i       (cfg_if),
    .in_i        (in_if),
    .out_i       (out_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= NO_XFER_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : rx_ready
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // One pixel transfer, with random idle cycles ahead of it
  task automatic send_pixel(input logic cmd, input logic [imn_pkg::PIX_FIELD_W-1:0] pix,
                            input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.cmd   <= cmd;
    in_if.pixel <= pix;
    in_if.last  <= last;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
  endtask

  // Stop offering pixels and let every pending result come back
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_target(input logic [imn_pkg::CFG_W-1:0] value);
    wait_idle();
    cfg_if.valid      <= 1'b1;
    cfg_if.target_max <= value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Pixel value by image flavor: full range, dim, mostly black, extremes
  function automatic logic [imn_pkg::PIX_FIELD_W-1:0] rand_pixel(input int unsigned flavor);
    logic [imn_pkg::PIX_FIELD_W-1:0] p;
    case (flavor)
      0: p = 16'($urandom_range(65535));
      1: p = 16'($urandom_range(255));
      2: p = ($urandom_range(7) == 0) ? 16'($urandom_range(3)) : '0;
      default: begin
        case ($urandom_range(4))
          0: p = '0;
          1: p = 16'd1;
          2: p = 16'hFFFF;
          3: p = 16'h8000;
          default: p = 16'($urandom_range(65535));
        endcase
      end
    endcase
    return p;
  endfunction

  // Measure pass then scale pass of the same pixels; a few scale pixels are
  // replaced by random full-range values, and some measure passes miss their last flag
  task automatic send_image();
    logic [imn_pkg::PIX_FIELD_W-1:0] img[$];
    logic [imn_pkg::PIX_FIELD_W-1:0] p;
    int unsigned                     flavor;
    int unsigned                     npix;
    bit                              mark_last;
    flavor    = $urandom_range(3);
    npix      = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
    mark_last = ($urandom_range(5) != 0);
    for (int i = 0; i < npix; i++) begin
      p = rand_pixel(flavor);
      img.push_back(p);
      send_pixel(imn_pkg::CMD_MEASURE, p, mark_last && (i == npix - 1));
    end
    for (int i = 0; i < npix; i++) begin
      p = ($urandom_range(7) == 0) ? rand_pixel(0) : img[i];
      send_pixel(imn_pkg::CMD_SCALE, p, (i == npix - 1));
    end
  endtask

  task automatic send_noise();
    send_pixel(1'($urandom_range(1)), 16'($urandom_range(65535)), ($urandom_range(3) == 0));
  endtask

  initial begin : stimulus
    int unsigned               idle_send[3];
    int unsigned               idle_recv[3];
    logic [imn_pkg::CFG_W-1:0] targets[6];
    int                        goal;
    idle_send = '{19, 47, 0};
    idle_recv = '{47, 19, 0};
    targets   = '{16'hFFFF, 16'($urandom_range(65535, 1)), 16'd1,
                  16'($urandom_range(4095, 2)), 16'($urandom_range(16, 1)), 16'd255};

    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.cmd         = imn_pkg::CMD_MEASURE;
    in_if.pixel       = '0;
    in_if.last        = 1'b0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.target_max = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = idle_send[0];
    recv_idle_pct = idle_recv[0];

    // Scale pass before any measure: peak is zero
    send_pixel(imn_pkg::CMD_SCALE, 16'd100, 1'b0);
    send_pixel(imn_pkg::CMD_SCALE, 16'd0, 1'b1);
    // Last flag on the measure pass keeps the peak
    send_pixel(imn_pkg::CMD_MEASURE, 16'd0, 1'b0);
    send_pixel(imn_pkg::CMD_MEASURE, 16'hFFFF, 1'b1);
    send_pixel(imn_pkg::CMD_MEASURE, 16'd1234, 1'b0);
    send_pixel(imn_pkg::CMD_SCALE, 16'hFFFF, 1'b0);
    send_pixel(imn_pkg::CMD_SCALE, 16'd0, 1'b0);
    send_pixel(imn_pkg::CMD_SCALE, 16'd257, 1'b0);
    send_pixel(imn_pkg::CMD_SCALE, 16'd1, 1'b1);
    // All-zero image
    send_pixel(imn_pkg::CMD_MEASURE, 16'd0, 1'b1);
    send_pixel(imn_pkg::CMD_SCALE, 16'd0, 1'b1);
    // Scale pixel far above the peak saturates
    send_pixel(imn_pkg::CMD_MEASURE, 16'd10, 1'b1);
    send_pixel(imn_pkg::CMD_SCALE, 16'hFFFF, 1'b0);
    send_pixel(imn_pkg::CMD_SCALE, 16'd5, 1'b1);
    // Largest product
    write_target(16'hFFFF);
    send_pixel(imn_pkg::CMD_MEASURE, 16'd1, 1'b1);
    send_pixel(imn_pkg::CMD_SCALE, 16'hFFFF, 1'b0);
    send_pixel(imn_pkg::CMD_SCALE, 16'd1, 1'b1);
    // Smallest target
    write_target(16'd1);
    send_pixel(imn_pkg::CMD_MEASURE, 16'hFFFF, 1'b1);
    send_pixel(imn_pkg::CMD_SCALE, 16'hFFFF, 1'b0);
    send_pixel(imn_pkg::CMD_SCALE, 16'd32767, 1'b1);

    // Random images under each idling pattern, two targets per pattern
    for (int ph = 0; ph < 3; ph++) begin
      for (int k = 0; k < 2; k++) begin
        write_target(targets[2 * ph + k]);
        send_idle_pct = idle_send[ph];
        recv_idle_pct = idle_recv[ph];
        goal          = items_sent + ITEMS_PER_SETTING;
        if (ph == 2 && k == 0) begin
          // Long receiver hold-off while scale pixels keep coming
          hold_pending = 1'b1;
          send_pixel(imn_pkg::CMD_MEASURE, 16'd40000, 1'b1);
          for (int i = 0; i < 10; i++)
            send_pixel(imn_pkg::CMD_SCALE, 16'($urandom_range(65535)), (i == 9));
        end
        while (items_sent < goal) begin
          if ($urandom_range(99) < 85) send_image();
          else send_noise();
        end
      end
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
